@@ design/irc_pkg.sv @@
// ----------------------------------------------------------------------------
// irc_pkg
// Shared constants for the impulse response convolver: sizes, widths, the
// command and register codes, and the stream bus widths.
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int MAX_TAPS   = 4096;
    localparam int SAMPLE_W   = 24;
    localparam int ADDR_W     = $clog2(MAX_TAPS);
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int IDX_W      = 12;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = PROD_W + ADDR_W;
    localparam int FRAC_SHIFT = SAMPLE_W - 1;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COUNT_W;

    localparam int S_TDATA_W  = ((IDX_W + SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TAP    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 1'b1;

endpackage

@@ design/impulse_response_convolver_core.sv @@
// ----------------------------------------------------------------------------
// impulse_response_convolver_core
// Direct-form FIR convolver of a mono Q1.23 stream with a stored impulse
// response of up to 4096 taps, one multiply-accumulate per tap.
// ----------------------------------------------------------------------------
// After reset the block sweeps the sample history to zero, one entry per cycle;
// input ready stays low during that sweep while configuration writes are taken
// as usual. A tap write (tuser 1) is taken without leaving the idle state and
// gives no output beat. A sample with bypass set is held in the result register
// and passed unchanged to the output register, and the input reopens as that
// output register is loaded. A sample with bypass clear is processed in steps:
// the history and tap memories are each read once per tap, one tap per cycle
// through a single registered multiplier and a 60-bit accumulator, then the
// multiplier pipeline drains, the sum is rounded and saturated, and the result
// is loaded into the output register; the input reopens with that load. A tap
// count of zero counts as one tap and one above 4096 as 4096. The output
// register lets the next item be accepted while a result still waits for the
// downstream side; a second result then waits until that beat is taken.
module impulse_response_convolver_core
    import irc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // tap_index, value, zero pad
    input  logic                  s_axis_tuser,   // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata    // sample_out
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_MAC    = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_ROUND  = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    t_state r_state, n_state;

    logic [COUNT_W-1:0]  r_tap_count;
    logic                r_bypass;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_k, n_k;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [ADDR_W-1:0]   r_last_k, n_last_k;
    logic                r_s1_valid;
    logic                r_s2_valid;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_result;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;

    logic                w_accept;
    logic [IDX_W-1:0]    w_tap_index;
    logic [SAMPLE_W-1:0] w_value;
    logic                w_sample_conv;
    logic                w_hist_we;
    logic [ADDR_W-1:0]   w_hist_waddr;
    logic [SAMPLE_W-1:0] w_hist_wdata;
    logic                w_taps_we;
    logic [SAMPLE_W-1:0] w_hist_rdata;
    logic [SAMPLE_W-1:0] w_taps_rdata;
    logic [ACC_W-1:0]    w_sum;
    logic [Q_W-1:0]      w_q;
    logic                w_q_fits;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic                w_out_free;

    assign w_tap_index   = s_axis_tdata[IDX_W-1:0];
    assign w_value       = s_axis_tdata[IDX_W +: SAMPLE_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_sample_conv = w_accept && (s_axis_tuser == CMD_SAMPLE) && !r_bypass;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // The history is written at the accepting edge and first read in the cycle
    // after it, so the read and write of the newest entry never overlap.
    assign w_hist_we    = (r_state == ST_CLEAR) || w_sample_conv;
    assign w_hist_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_ptr;
    assign w_hist_wdata = (r_state == ST_CLEAR) ? '0 : w_value;
    assign w_taps_we    = w_accept && (s_axis_tuser == CMD_TAP);

    irc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_history_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_hist_rdata)
    );

    irc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_taps_ram (
        .i_clk   (i_clk),
        .i_we    (w_taps_we),
        .i_waddr (ADDR_W'(w_tap_index)),
        .i_wdata (w_value),
        .i_raddr (r_k),
        .o_rdata (w_taps_rdata)
    );

    // Number of taps in use, clamped to 1 .. MAX_TAPS, held as the last index.
    always_comb begin
        if (r_tap_count == '0) begin
            n_last_k = '0;
        end else if (r_tap_count > COUNT_W'(MAX_TAPS)) begin
            n_last_k = LAST_ADDR;
        end else begin
            n_last_k = ADDR_W'(r_tap_count - COUNT_W'(1));
        end
    end

    // Round half up, then saturate to the sample range.
    assign w_sum    = r_acc + ROUND_HALF;
    assign w_q      = w_sum[ACC_W-1:FRAC_SHIFT];
    assign w_q_fits = (&w_q[Q_W-1:SAMPLE_W-1]) || !(|w_q[Q_W-1:SAMPLE_W-1]);
    assign w_sat    = w_q_fits ? w_q[SAMPLE_W-1:0] : (w_q[Q_W-1] ? SAT_MIN : SAT_MAX);

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_k     = r_k;
        n_pos   = r_pos;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && (s_axis_tuser == CMD_SAMPLE)) begin
                    if (r_bypass) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_MAC;
                        n_k     = '0;
                        n_pos   = r_ptr;
                        n_ptr   = (r_ptr == LAST_ADDR) ? '0 : r_ptr + ADDR_W'(1);
                    end
                end
            end
            ST_MAC: begin
                n_k   = r_k + ADDR_W'(1);
                n_pos = (r_pos == '0) ? LAST_ADDR : r_pos - ADDR_W'(1);
                if (r_k == r_last_k) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_tap_count <= COUNT_W'(1);
            r_bypass    <= 1'b1;
            r_ptr       <= '0;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_s1_valid <= (r_state == ST_MAC);
            r_s2_valid <= r_s1_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TAP_COUNT: r_tap_count <= i_cfg_data;
                    CFG_BYPASS:    r_bypass    <= i_cfg_data[0];
                    default:       ;
                endcase
            end
            if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_pos <= n_pos;
        if (w_sample_conv) begin
            r_last_k <= n_last_k;
            r_acc    <= '0;
        end else if (r_s2_valid) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (r_s1_valid) begin
            r_prod <= $signed(w_taps_rdata) * $signed(w_hist_rdata);
        end
        if (w_accept && (s_axis_tuser == CMD_SAMPLE)) begin
            r_result <= w_value;
        end else if (r_state == ST_ROUND) begin
            r_result <= w_sat;
        end
        if ((r_state == ST_FINISH) && w_out_free) begin
            r_out_data <= r_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_data);

endmodule

@@ design/irc_ram.sv @@
// ----------------------------------------------------------------------------
// irc_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module irc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/irc_checker.sv @@
// ----------------------------------------------------------------------------
// irc_checker
// Port-level checks on the convolver core, attached by a bind statement.
// ----------------------------------------------------------------------------
module irc_checker
    import irc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TDATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata
);

    // The history sweep after reset keeps the input closed.
    a_closed_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // A stalled output beat holds its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    // A tap write leaves the input ready for the next beat.
    a_tap_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TAP) |=> s_axis_tready)
        else $error("input not ready after a tap write");

    // A sample occupies the datapath for at least the following cycle.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SAMPLE) |=> !s_axis_tready)
        else $error("input ready right after a sample beat");

endmodule

bind impulse_response_convolver_core irc_checker u_irc_checker (.*);

@@ tb/impulse_response_convolver_core_tb.sv @@
// ----------------------------------------------------------------------------
// impulse_response_convolver_core_tb
// Self-checking testbench for the FIR convolver core. A predictor in this
// file keeps its own copy of the sample history, the coefficients and the
// two registers, and computes every filtered output sample exactly at full
// precision, then rounds and saturates it. Directed tests cover bypass, rounding ties,
// saturation and tap counts from zero up to the full loaded response. Random
// traffic then runs under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module impulse_response_convolver_core_tb;
    import irc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    localparam t_sample SAMPLE_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam int      MAX_GAP     = 40;
    localparam int      SETTLE_CYC  = 16;
    localparam int      LOADED_TAPS = 32;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata   = '0;   // tap_index, value, zero pad
    logic                  s_axis_tuser   = 1'b0; // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;          // sample_out

    impulse_response_convolver_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state.
    t_sample               hist_mem [MAX_TAPS];
    t_sample               coef_mem [MAX_TAPS];
    logic [ADDR_W-1:0]     hist_wr_ptr;
    logic [CFG_DATA_W-1:0] cur_tap_count;
    logic                  cur_bypass;

    t_sample               expected_samples [$];
    int                    mismatch_count  = 0;
    int                    sender_idle_pct = 0;
    int                    recv_stall_pct  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void reset_predictor();
        for (int k = 0; k < MAX_TAPS; k++) begin
            hist_mem[k] = '0;
            coef_mem[k] = '0;
        end
        hist_wr_ptr   = '0;
        cur_tap_count = CFG_DATA_W'(1);
        cur_bypass    = 1'b1;
    endfunction

    // Pushes one sample into the history and returns the filtered output:
    // exact sum of products, round half up, then clamp to the sample range.
    function automatic t_sample convolve_sample(input t_sample x);
        longint            acc;
        longint            q;
        longint            maxv;
        int                n;
        logic [ADDR_W-1:0] pos;
        maxv = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        hist_mem[hist_wr_ptr] = x;
        n = cur_tap_count;
        if (n == 0)
            n = 1;
        if (n > MAX_TAPS)
            n = MAX_TAPS;
        pos = hist_wr_ptr;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            acc += longint'(coef_mem[k]) * longint'(hist_mem[pos]);
            pos = pos - 1'b1;
        end
        hist_wr_ptr = hist_wr_ptr + 1'b1;
        q = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (q > maxv)
            q = maxv;
        if (q < -maxv - 1)
            q = -maxv - 1;
        return t_sample'(q);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int draw_gap();
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            g++;
        return g;
    endfunction

    function automatic t_sample random_sample();
        t_sample v;
        v = t_sample'($urandom);
        case ($urandom_range(3))
            0: v = v >>> 9;
            1: v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            default: ;
        endcase
        return v;
    endfunction

    task automatic set_idling(input int sender_pct, input int recv_pct);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
    endtask

    // Sends one beat and updates the predictor when the beat is taken.
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input t_sample val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_TDATA_W - IDX_W - SAMPLE_W){1'b0}}, val, idx};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        if (cmd == CMD_TAP)
            coef_mem[idx] = val;
        else if (cur_bypass)
            expected_samples.push_back(val);
        else
            expected_samples.push_back(convolve_sample(val));
    endtask

    task automatic send_sample(input t_sample val);
        send_item(CMD_SAMPLE, logic'($urandom) ? '1 : '0, val);
    endtask

    task automatic send_tap(input logic [IDX_W-1:0] idx, input t_sample val);
        send_item(CMD_TAP, idx, val);
    endtask

    // Drains all outstanding results, then leaves room for a trailing tap
    // write to finish before any register is touched.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_samples.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TAP_COUNT)
            cur_tap_count = data;
        else
            cur_bypass = data[0];
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_output
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected output beat %h", m_axis_tdata));
            end else begin
                want = expected_samples.pop_front();
                if (m_axis_tdata !== M_TDATA_W'(want))
                    report_mismatch($sformatf("sample_out %h, expected %h",
                                              m_axis_tdata, want));
            end
        end
    end

    // Out of reset the block bypasses; tap writes are taken all the same.
    task automatic test_bypass_after_reset();
        set_idling(0, 0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(t_sample'(-1));
        send_tap('0, SAMPLE_MIN);
        send_tap('1, SAMPLE_MAX);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
    endtask

    // The first LOADED_TAPS coefficients are written, and every tap count
    // used later stays within them. Far taps are kept small so that longer
    // responses do not always clip.
    task automatic test_tap_load();
        t_sample v;
        set_idling(0, 0);
        for (int k = 0; k < LOADED_TAPS; k++) begin
            v = t_sample'($urandom);
            if (k >= 16)
                v = v >>> 10;
            send_tap(IDX_W'(k), v);
        end
    endtask

    task automatic test_rounding_and_saturation();
        set_idling(85, 0);
        wait_idle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(1));
        // Upper data bits set: only bit 0 selects bypass.
        write_reg(CFG_BYPASS, 13'h1FFE);
        send_tap(IDX_W'(0), t_sample'(1));
        // Exact ties round upward in both signs.
        send_sample(24'sh400000);
        send_sample(24'shC00000);
        send_sample(24'shC00001);
        send_tap(IDX_W'(0), SAMPLE_MIN);
        // Full negative times full negative overflows the positive range.
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_tap(IDX_W'(1), SAMPLE_MIN);
        wait_idle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(2));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        wait_idle();
        // A tap count of zero behaves as one tap.
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(0));
        send_sample(24'sh123456);
    endtask

    // The whole loaded response, then one tap short of it.
    task automatic test_tap_count_limits();
        set_idling(0, 85);
        wait_idle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(LOADED_TAPS));
        send_sample(random_sample());
        send_sample(random_sample());
        send_sample(random_sample());
        wait_idle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(LOADED_TAPS - 1));
        send_sample(random_sample());
        send_sample(random_sample());
    endtask

    // Bypassed samples must not enter the history.
    task automatic test_bypass_freezes_history();
        set_idling(7, 7);
        wait_idle();
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(4));
        write_reg(CFG_BYPASS, 13'h1FFF);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sh0F0F0F);
        wait_idle();
        write_reg(CFG_BYPASS, 13'h0000);
        send_sample(random_sample());
        send_sample(random_sample());
        send_sample(random_sample());
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] count;
        logic [CFG_DATA_W-1:0] upper;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(85, 0);
                2: set_idling(0, 85);
                default: set_idling(7, 7);
            endcase
            wait_idle();
            case ($urandom_range(3))
                0: count = CFG_DATA_W'($urandom_range(8, 1));
                1: count = CFG_DATA_W'($urandom_range(16, 9));
                2: count = CFG_DATA_W'($urandom_range(LOADED_TAPS, 17));
                default: count = CFG_DATA_W'($urandom_range(16, 0));
            endcase
            upper = CFG_DATA_W'($urandom);
            write_reg(CFG_TAP_COUNT, count);
            write_reg(CFG_BYPASS, {upper[CFG_DATA_W-1:1], ($urandom_range(3) == 0)});
            for (int n = 0; n < 20; n++) begin
                if ($urandom_range(99) < 25)
                    send_tap(IDX_W'($urandom), t_sample'($urandom) >>> $urandom_range(12));
                else
                    send_sample(random_sample());
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_bypass_after_reset();
        test_tap_load();
        test_rounding_and_saturation();
        test_tap_count_limits();
        test_bypass_freezes_history();
        test_random_traffic();
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
